### sv/dual_quadrature_decoder_macros.svh
// -----------------------------------------------------------------------------
// Dual quadrature decoder assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_DECODER_MACROS_SVH
`define DUAL_QUADRATURE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DQD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/dqd_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder package
// Request codes, register map, step table and per-channel control type.
// -----------------------------------------------------------------------------
package dqd_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_LEFT_REVERSE  = 1'b0;
   localparam logic REG_RIGHT_REVERSE = 1'b1;

   localparam logic [2:0] REQ_EDGE       = 3'd0;
   localparam logic [2:0] REQ_READ_LEFT  = 3'd1;
   localparam logic [2:0] REQ_READ_RIGHT = 3'd2;
   localparam logic [2:0] REQ_CLEAR      = 3'd3;
   localparam logic [2:0] REQ_INIT       = 3'd4;

   localparam logic signed [31:0] ACC_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] ACC_MIN = 32'sh8000_0000;
   localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
   localparam logic signed [15:0] OUT_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      STEP_HOLD,
      STEP_UP,
      STEP_DOWN
   } step_type;

   typedef struct packed {
      logic step;
      logic take;
      logic clear;
      logic init;
   } chan_ctl_type;

   function automatic step_type step_code(input logic [3:0] idx);
      step_type code;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:   code = STEP_UP;
         4'd2, 4'd4, 4'd11, 4'd13:  code = STEP_DOWN;
         default:                   code = STEP_HOLD;
      endcase
      return code;
   endfunction

endpackage

### sv/dqd_req_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder request channel
// Valid/ready channel carrying one request beat.
// -----------------------------------------------------------------------------
interface dqd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [1:0] left_ab;
   logic [1:0] right_ab;
   logic       left_changed;
   logic       right_changed;

   modport source (
      output valid, req_type, left_ab, right_ab, left_changed, right_changed,
      input  ready
   );
   modport sink (
      input  valid, req_type, left_ab, right_ab, left_changed, right_changed,
      output ready
   );
endinterface

### sv/dqd_rsp_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder response channel
// Valid/ready channel carrying one result beat.
// -----------------------------------------------------------------------------
interface dqd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] delta_out;
   logic        [31:0] left_illegal_count;
   logic        [31:0] right_illegal_count;

   modport source (
      output valid, delta_out, left_illegal_count, right_illegal_count,
      input  ready
   );
   modport sink (
      input  valid, delta_out, left_illegal_count, right_illegal_count,
      output ready
   );
endinterface

### sv/dual_quadrature_decoder.sv
// A request beat is held in the input stage, then its result is registered for rsp.
// One request per cycle unless rsp stalls; the input stage refills as a result is taken.
// Each channel computes step, accumulate and count update combinationally into registers.
// Reset is synchronous: deltas, illegal counts, previous states and reverse bits go to zero.
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder
// Two-channel 4x quadrature decoder with saturating deltas and illegal counts.
// -----------------------------------------------------------------------------
module dual_quadrature_decoder (
   input  logic                            clock,
   input  logic                            reset,
   dqd_req_if.sink                         req,
   dqd_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dqd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dqd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dqd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   logic                  stage_valid_ff;
   logic [2:0]            req_type_ff;
   logic [1:0]            left_ab_ff;
   logic [1:0]            right_ab_ff;
   logic                  left_changed_ff;
   logic                  right_changed_ff;
   logic                  rsp_valid_ff;
   logic signed [15:0]    delta_ff;
   logic signed [15:0]    delta_in;
   logic [31:0]           left_bad_ff;
   logic [31:0]           right_bad_ff;
   logic [31:0]           left_bad_in;
   logic [31:0]           right_bad_in;
   logic signed [15:0]    left_delta;
   logic signed [15:0]    right_delta;
   logic                  advance;
   logic                  left_reverse;
   logic                  right_reverse;
   dqd_pkg::chan_ctl_type left_ctl;
   dqd_pkg::chan_ctl_type right_ctl;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req.ready) begin
            stage_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req.valid && req.ready) begin
         req_type_ff      <= req.req_type;
         left_ab_ff       <= req.left_ab;
         right_ab_ff      <= req.right_ab;
         left_changed_ff  <= req.left_changed;
         right_changed_ff <= req.right_changed;
      end
      if (advance) begin
         delta_ff     <= delta_in;
         left_bad_ff  <= left_bad_in;
         right_bad_ff <= right_bad_in;
      end
   end

   always_comb begin
      left_ctl  = '0;
      right_ctl = '0;
      delta_in  = '0;
      unique case (req_type_ff)
         dqd_pkg::REQ_EDGE: begin
            left_ctl.step  = advance && left_changed_ff;
            right_ctl.step = advance && right_changed_ff;
         end
         dqd_pkg::REQ_READ_LEFT: begin
            left_ctl.take = advance;
            delta_in      = left_delta;
         end
         dqd_pkg::REQ_READ_RIGHT: begin
            right_ctl.take = advance;
            delta_in       = right_delta;
         end
         dqd_pkg::REQ_CLEAR: begin
            left_ctl.clear  = advance;
            right_ctl.clear = advance;
         end
         dqd_pkg::REQ_INIT: begin
            left_ctl.init  = advance;
            right_ctl.init = advance;
         end
         default: ;
      endcase
   end

   dqd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .left_reverse  (left_reverse),
      .right_reverse (right_reverse)
   );

   dqd_chan u_left (
      .clock   (clock),
      .reset   (reset),
      .ctl     (left_ctl),
      .ab      (left_ab_ff),
      .reverse (left_reverse),
      .delta   (left_delta),
      .bad_in  (left_bad_in)
   );

   dqd_chan u_right (
      .clock   (clock),
      .reset   (reset),
      .ctl     (right_ctl),
      .ab      (right_ab_ff),
      .reverse (right_reverse),
      .delta   (right_delta),
      .bad_in  (right_bad_in)
   );

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.delta_out           = delta_ff;
   assign rsp.left_illegal_count  = left_bad_ff;
   assign rsp.right_illegal_count = right_bad_ff;

endmodule

### sv/dqd_csr.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder register file
// APB-style port holding the two direction reverse bits.
// -----------------------------------------------------------------------------
module dqd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dqd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [dqd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [dqd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic                            left_reverse,
   output logic                            right_reverse
);

   logic left_reverse_ff;
   logic right_reverse_ff;
   logic wr_en;
   logic reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_reverse_ff  <= 1'b0;
         right_reverse_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_sel)
            dqd_pkg::REG_LEFT_REVERSE:  left_reverse_ff  <= pwdata[0];
            dqd_pkg::REG_RIGHT_REVERSE: right_reverse_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         dqd_pkg::REG_LEFT_REVERSE:  prdata[0] = left_reverse_ff;
         dqd_pkg::REG_RIGHT_REVERSE: prdata[0] = right_reverse_ff;
         default: ;
      endcase
   end

   assign left_reverse  = left_reverse_ff;
   assign right_reverse = right_reverse_ff;

endmodule

### sv/dqd_chan.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder channel
// Step lookup, saturating delta accumulator and illegal transition counter.
// -----------------------------------------------------------------------------
`include "dual_quadrature_decoder_macros.svh"

module dqd_chan (
   input  logic                  clock,
   input  logic                  reset,
   input  dqd_pkg::chan_ctl_type ctl,
   input  logic [1:0]            ab,
   input  logic                  reverse,
   output logic signed [15:0]    delta,
   output logic [31:0]           bad_in
);

   logic        [1:0]  prev_ff;
   logic        [1:0]  prev_in;
   logic signed [31:0] accum_ff;
   logic signed [31:0] accum_in;
   logic        [31:0] bad_ff;
   dqd_pkg::step_type  step;
   logic               up;
   logic               fits;

   always_comb begin
      step     = dqd_pkg::step_code({prev_ff, ab});
      up       = (step == dqd_pkg::STEP_UP) ^ reverse;
      accum_in = accum_ff;
      prev_in  = prev_ff;
      bad_in   = bad_ff;
      if (ctl.step) begin
         if (step != dqd_pkg::STEP_HOLD) begin
            if (up) begin
               if (accum_ff != dqd_pkg::ACC_MAX) accum_in = accum_ff + 32'sd1;
            end else begin
               if (accum_ff != dqd_pkg::ACC_MIN) accum_in = accum_ff - 32'sd1;
            end
         end else if (ab != prev_ff) begin
            bad_in = bad_ff + 32'd1;
         end
         prev_in = ab;
      end
      if (ctl.take || ctl.clear) begin
         accum_in = '0;
      end
      if (ctl.init) begin
         prev_in  = ab;
         accum_in = '0;
         bad_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         accum_ff <= '0;
         bad_ff   <= '0;
      end else begin
         prev_ff  <= prev_in;
         accum_ff <= accum_in;
         bad_ff   <= bad_in;
      end
   end

   assign fits = (accum_ff[31:15] == '0) || (accum_ff[31:15] == '1);

   always_comb begin
      if (fits) begin
         delta = accum_ff[15:0];
      end else if (accum_ff[31]) begin
         delta = dqd_pkg::OUT_MIN;
      end else begin
         delta = dqd_pkg::OUT_MAX;
      end
   end

   `DQD_ASSERT_NEXT(a_take_clears, ctl.take, accum_ff == '0, "read did not clear accumulator")
   `DQD_ASSERT_NEXT(a_init_loads, ctl.init, bad_ff == '0 && prev_ff == $past(ab),
      "init did not load state")
   `DQD_ASSERT_NEXT(a_idle_holds, ctl == '0, $stable(accum_ff) && $stable(bad_ff),
      "channel state moved without a request")
   `DQD_ASSERT_SAME(a_bad_step, bad_in != bad_ff && !ctl.init,
      ctl.step && step == dqd_pkg::STEP_HOLD, "illegal count moved on a legal step")

endmodule

### tb/tb_dual_quadrature_decoder.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dual quadrature decoder testbench
// Drives request beats into the decoder and predicts every result beat from
// an independent model of both channels: gray-code position steps, direction
// reversal, saturating deltas and illegal transition counts. Directed cases
// come first, then a long run of steps in one direction on each channel,
// every reverse setting, and a random stream of mostly well-formed pin
// sequences. Both handshake sides idle at random.
// -----------------------------------------------------------------------------
module tb_dual_quadrature_decoder;

   localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
   localparam logic [2:0] REQ_RESERVED_HI = 3'd7;
   localparam int IDLE_LIMIT = 2000;
   localparam int RUN_STEPS = 300;
   localparam logic signed [31:0] DELTA_HI = dqd_pkg::OUT_MAX;
   localparam logic signed [31:0] DELTA_LO = dqd_pkg::OUT_MIN;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] lab;
      logic [1:0] rab;
      logic       lch;
      logic       rch;
   } quad_req_type;

   typedef struct packed {
      logic signed [15:0] delta;
      logic [31:0]        lcnt;
      logic [31:0]        rcnt;
   } quad_rsp_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [dqd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dqd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dqd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   dqd_req_if req_if ();
   dqd_rsp_if rsp_if ();

   dual_quadrature_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic              rev_l, rev_r;
   logic [1:0]        prev_l, prev_r;
   logic signed [31:0] acc_l, acc_r;
   logic [31:0]       bad_l, bad_r;

   quad_rsp_type readout_queue[$];
   int mismatches = 0;
   int gap_max = 16;
   int stall_max = 16;
   int idle_cycles = 0;
   logic [1:0] pins_l = 2'd0;
   logic [1:0] pins_r = 2'd0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [1:0] pin_pos(input logic [1:0] ab);
      return {ab[1], ab[1] ^ ab[0]};
   endfunction

   function automatic logic [1:0] pos_pins(input logic [1:0] p);
      return {p[1], p[1] ^ p[0]};
   endfunction

   task automatic step_channel(input logic [1:0] cur, inout logic [1:0] prev,
                               inout logic signed [31:0] acc, inout logic [31:0] bad,
                               input logic rev);
      logic [1:0] diff;
      logic up, down;
      diff = pin_pos(cur) - pin_pos(prev);
      up = (diff == 2'd1) ^ ((diff != 2'd0 && diff != 2'd2) && rev);
      down = (diff == 2'd3) ^ ((diff != 2'd0 && diff != 2'd2) && rev);
      if (up) begin
         if (acc != dqd_pkg::ACC_MAX) acc = acc + 32'sd1;
      end else if (down) begin
         if (acc != dqd_pkg::ACC_MIN) acc = acc - 32'sd1;
      end else if (cur != prev) begin
         bad = bad + 32'd1;
      end
      prev = cur;
   endtask

   function automatic logic signed [15:0] clamp_delta(input logic signed [31:0] v);
      if (v > DELTA_HI) return dqd_pkg::OUT_MAX;
      if (v < DELTA_LO) return dqd_pkg::OUT_MIN;
      return v[15:0];
   endfunction

   task automatic advance_decoder(input quad_req_type r, output quad_rsp_type e);
      e.delta = '0;
      case (r.kind)
         dqd_pkg::REQ_EDGE: begin
            if (r.lch) step_channel(r.lab, prev_l, acc_l, bad_l, rev_l);
            if (r.rch) step_channel(r.rab, prev_r, acc_r, bad_r, rev_r);
         end
         dqd_pkg::REQ_READ_LEFT: begin
            e.delta = clamp_delta(acc_l);
            acc_l = '0;
         end
         dqd_pkg::REQ_READ_RIGHT: begin
            e.delta = clamp_delta(acc_r);
            acc_r = '0;
         end
         dqd_pkg::REQ_CLEAR: begin
            acc_l = '0;
            acc_r = '0;
         end
         dqd_pkg::REQ_INIT: begin
            prev_l = r.lab;
            prev_r = r.rab;
            acc_l = '0;
            acc_r = '0;
            bad_l = '0;
            bad_r = '0;
         end
         default: begin
         end
      endcase
      e.lcnt = bad_l;
      e.rcnt = bad_r;
   endtask

   task automatic send_request(input quad_req_type r);
      quad_rsp_type e;
      int gap;
      gap = (gap_max > 0) ? int'($urandom_range(0, gap_max)) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= r.kind;
      req_if.left_ab <= r.lab;
      req_if.right_ab <= r.rab;
      req_if.left_changed <= r.lch;
      req_if.right_changed <= r.rch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      advance_decoder(r, e);
      readout_queue.push_back(e);
   endtask

   task automatic send_fields(input logic [2:0] kind, input logic [1:0] lab,
                              input logic [1:0] rab, input logic lch, input logic rch);
      quad_req_type r;
      r = '{kind: kind, lab: lab, rab: rab, lch: lch, rch: rch};
      send_request(r);
   endtask

   task automatic wait_for_quiet();
      req_if.valid <= 1'b0;
      while (readout_queue.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic value);
      wait_for_quiet();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == dqd_pkg::REG_LEFT_REVERSE) rev_l = value;
      else rev_r = value;
   endtask

   function automatic logic [1:0] next_pins(input logic [1:0] ab);
      int pick;
      logic [1:0] p;
      pick = $urandom_range(0, 99);
      p = pin_pos(ab);
      if (pick < 40) p = p + 2'd1;
      else if (pick < 75) p = p - 2'd1;
      else if (pick < 85) p = p + 2'd2;
      else if (pick >= 95) p = 2'($urandom());
      return pos_pins(p);
   endfunction

   task automatic draw_request(output quad_req_type r);
      int pick;
      logic [1:0] nl, nr;
      pick = $urandom_range(0, 99);
      r = '{kind: dqd_pkg::REQ_EDGE, lab: pins_l, rab: pins_r, lch: 1'b0, rch: 1'b0};
      if ($urandom_range(0, 99) < 8) begin
         r = quad_req_type'(9'($urandom()));
      end else if (pick < 75) begin
         nl = next_pins(pins_l);
         nr = next_pins(pins_r);
         r.lab = nl;
         r.rab = nr;
         r.lch = (nl != pins_l) ? ($urandom_range(0, 19) != 0) : 1'($urandom());
         r.rch = (nr != pins_r) ? ($urandom_range(0, 19) != 0) : 1'($urandom());
         pins_l = nl;
         pins_r = nr;
      end else begin
         r.lch = 1'($urandom());
         r.rch = 1'($urandom());
         if (pick < 83) r.kind = dqd_pkg::REQ_READ_LEFT;
         else if (pick < 91) r.kind = dqd_pkg::REQ_READ_RIGHT;
         else if (pick < 94) r.kind = dqd_pkg::REQ_CLEAR;
         else if (pick < 97) r.kind = dqd_pkg::REQ_INIT;
         else r.kind = 3'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
      end
   endtask

   task automatic run_random(input int count);
      quad_req_type r;
      for (int i = 0; i < count; i++) begin
         draw_request(r);
         send_request(r);
      end
   endtask

   task automatic test_directed();
      send_fields(dqd_pkg::REQ_EDGE, 2'd1, 2'd2, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd2, 2'd1, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd0, 2'd0, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_READ_LEFT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_READ_RIGHT, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd3, 2'd3, 1'b1, 1'b0);
      send_fields(dqd_pkg::REQ_EDGE, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(REQ_RESERVED_LO, 2'd1, 2'd2, 1'b1, 1'b1);
      send_fields(REQ_RESERVED_LO + 3'd1, 2'd3, 2'd0, 1'b0, 1'b1);
      send_fields(REQ_RESERVED_HI, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_EDGE, 2'd1, 2'd1, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_CLEAR, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_READ_LEFT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_READ_RIGHT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_INIT, 2'd2, 2'd1, 1'b0, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd0, 2'd0, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_READ_LEFT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_READ_RIGHT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_INIT, 2'd3, 2'd3, 1'b1, 1'b1);
      send_fields(dqd_pkg::REQ_EDGE, 2'd0, 2'd0, 1'b1, 1'b1);
   endtask

   task automatic test_long_run();
      logic [1:0] pl, pr;
      gap_max = 0;
      stall_max = 0;
      pl = 2'd0;
      pr = 2'd0;
      send_fields(dqd_pkg::REQ_INIT, 2'd0, 2'd0, 1'b0, 1'b0);
      for (int k = 0; k < RUN_STEPS; k++) begin
         pl = pl + 2'd1;
         pr = pr - 2'd1;
         send_fields(dqd_pkg::REQ_EDGE, pos_pins(pl), pos_pins(pr), 1'b1, 1'b1);
      end
      send_fields(dqd_pkg::REQ_READ_LEFT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_READ_RIGHT, 2'd0, 2'd0, 1'b0, 1'b0);
      send_fields(dqd_pkg::REQ_READ_LEFT, 2'd0, 2'd0, 1'b0, 1'b0);
      pins_l = pos_pins(pl);
      pins_r = pos_pins(pr);
      gap_max = 16;
      stall_max = 16;
   endtask

   task automatic test_reverse_settings();
      csr_write(dqd_pkg::REG_LEFT_REVERSE, 1'b1);
      run_random(100);
      csr_write(dqd_pkg::REG_RIGHT_REVERSE, 1'b1);
      run_random(100);
      csr_write(dqd_pkg::REG_LEFT_REVERSE, 1'b0);
      run_random(100);
      csr_write(dqd_pkg::REG_RIGHT_REVERSE, 1'b0);
      run_random(100);
   endtask

   task automatic test_random_stream();
      run_random(250);
      wait_for_quiet();
      gap_max = 0;
      stall_max = 0;
      run_random(150);
      gap_max = 16;
      stall_max = 16;
      run_random(150);
      stall_max = 0;
      run_random(100);
      gap_max = 0;
      stall_max = 16;
      run_random(50);
      gap_max = 16;
      run_random(100);
   endtask

   initial begin : result_sink
      quad_rsp_type got, want;
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (stall_max > 0) ? int'($urandom_range(0, stall_max)) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         got = '{delta: rsp_if.delta_out, lcnt: rsp_if.left_illegal_count,
                 rcnt: rsp_if.right_illegal_count};
         if (readout_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: delta %0d left %0d right %0d",
                        got.delta, got.lcnt, got.rcnt);
         end else begin
            want = readout_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: delta exp %0d got %0d, left exp %0d got %0d,",
                            " right exp %0d got %0d"},
                           want.delta, got.delta, want.lcnt, got.lcnt,
                           want.rcnt, got.rcnt);
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.req_type <= dqd_pkg::REQ_EDGE;
      req_if.left_ab <= 2'd0;
      req_if.right_ab <= 2'd0;
      req_if.left_changed <= 1'b0;
      req_if.right_changed <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      rev_l = 1'b0;
      rev_r = 1'b0;
      prev_l = 2'd0;
      prev_r = 2'd0;
      acc_l = '0;
      acc_r = '0;
      bad_l = '0;
      bad_r = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_run();
      test_reverse_settings();
      test_random_stream();
      wait_for_quiet();
      repeat (6) @(posedge clock);
      if (readout_queue.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/dqd_pkg.sv
sv/dqd_req_if.sv
sv/dqd_rsp_if.sv
sv/dqd_csr.sv
sv/dqd_chan.sv
sv/dual_quadrature_decoder.sv
tb/tb_dual_quadrature_decoder.sv
